// File: src/window_velocity_accel_estimator_defines.svh
// Assertion macros shared by the estimator RTL.
`ifndef WINDOW_VELOCITY_ACCEL_ESTIMATOR_DEFINES_SVH
`define WINDOW_VELOCITY_ACCEL_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WVAE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define WVAE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/wvae_pkg.sv
// Package with types, widths and codes of the window velocity estimator.
`timescale 1ns / 1ps
package wvae_pkg;

  localparam int WINDOW_DEPTH_DEF = 5;
  localparam int JOINTS_DEF       = 6;

  localparam int JOINT_W = 4;
  localparam int VEL_W   = 32;
  localparam int ACC_W   = 48;
  localparam int VP_W    = 38;

  localparam int DIV_BITS  = 60;
  localparam int DIVISOR_W = 33;
  localparam int CNT_W     = $clog2(DIV_BITS + 1);
  localparam int MUL_A_W   = 19;
  localparam int MUL_K_W   = 20;
  localparam int MUL_P_W   = MUL_A_W + MUL_K_W;

  localparam logic [MUL_K_W-1:0] USEC_K = MUL_K_W'(1000000);

  localparam int OP_W = 1;
  localparam logic [OP_W-1:0] OP_MUL = 1'b0;
  localparam logic [OP_W-1:0] OP_DIV = 1'b1;

  typedef struct packed {
    logic               hand;
    logic               read_ok;
    logic [31:0]        time_us;
    logic signed [15:0] pos_a;
    logic signed [15:0] pos_b;
    logic signed [15:0] pos_c;
    logic signed [15:0] pos_d;
    logic signed [15:0] pos_e;
    logic signed [15:0] pos_f;
  } sample_t;

  typedef struct packed {
    logic [3:0]         joint;
    logic signed [15:0] position;
    logic signed [31:0] velocity;
    logic signed [47:0] acceleration;
    logic [31:0]        lost_count;
    logic               last;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: src/wvae_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module wvae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 60
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/wvae_unit.sv
// Shared arithmetic unit: registered constant multiply and bit-serial divide.
`timescale 1ns / 1ps
`include "window_velocity_accel_estimator_defines.svh"
module wvae_unit
  import wvae_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  unit_req_t            req,
  input  logic [DIV_BITS-1:0]  opa,
  input  logic [DIVISOR_W-1:0] opb,
  output unit_stat_t           stat,
  output logic [DIV_BITS-1:0]  quotient
);

  logic                 busy;
  logic                 done;
  logic [OP_W-1:0]      op;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_BITS-1:0]  acc;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [MUL_P_W-1:0]   prod;

  assign trial = {rem, acc[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign prod  = opa[MUL_A_W-1:0] * USEC_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op <= req.op;
        if (req.op == OP_MUL) begin
          acc  <= DIV_BITS'(prod);
          done <= 1'b1;
        end else begin
          acc     <= opa;
          rem     <= '0;
          divisor <= opb;
          cnt     <= CNT_W'(DIV_BITS);
          busy    <= 1'b1;
        end
      end else if (busy) begin
        rem <= fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
        acc <= {acc[DIV_BITS-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = acc;

  `WVAE_ASSERT_IMP(a_start_idle, clk, rst, req.start, !busy)
  `WVAE_ASSERT_NEXT(a_mul_one, clk, rst, req.start && (req.op == OP_MUL), done)
  `WVAE_ASSERT_IMP(a_div_done_cnt, clk, rst, done && (op == OP_DIV), cnt == '0)

endmodule

// File: src/window_velocity_accel_estimator.sv
// Top level of the windowed finite-difference velocity and acceleration estimator.
`timescale 1ns / 1ps
`include "window_velocity_accel_estimator_defines.svh"
// Each transaction carries one timestamped joint sample for one hand and returns one result
// per joint of that hand. The block takes one transaction at a time and raises sample_stall
// until the last result has left. A failed read skips the window update and goes straight
// to the results. The time per good sample is set by the shared arithmetic unit, whose
// divider retires one quotient bit a cycle over 60 bits, with one division per joint for
// velocity and four with acceleration. No clearing pass follows reset.
module window_velocity_accel_estimator
  import wvae_pkg::*;
#(
  parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
  parameter int JOINTS_PER_HAND = JOINTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int D      = WINDOW_DEPTH;
  localparam int J      = JOINTS_PER_HAND;
  localparam int SW     = $clog2(D);
  localparam int FW     = $clog2(D + 1);
  localparam int JW     = (J > 1) ? $clog2(J) : 1;
  localparam int HW     = $clog2(2 * J);
  localparam int PDEPTH = 2 * D * J;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int TDEPTH = 2 * D;
  localparam int TAW    = $clog2(TDEPTH);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] S_WRITE   = 5'd1;
  localparam logic [ST_W-1:0] S_RT0     = 5'd2;
  localparam logic [ST_W-1:0] S_RT1     = 5'd3;
  localparam logic [ST_W-1:0] S_RT2     = 5'd4;
  localparam logic [ST_W-1:0] S_RT3     = 5'd5;
  localparam logic [ST_W-1:0] S_CHK     = 5'd6;
  localparam logic [ST_W-1:0] S_RQ0     = 5'd7;
  localparam logic [ST_W-1:0] S_RQ1     = 5'd8;
  localparam logic [ST_W-1:0] S_RQ2     = 5'd9;
  localparam logic [ST_W-1:0] S_RQ3     = 5'd10;
  localparam logic [ST_W-1:0] S_VMUL    = 5'd11;
  localparam logic [ST_W-1:0] S_VDIV    = 5'd12;
  localparam logic [ST_W-1:0] S_P_MUL   = 5'd13;
  localparam logic [ST_W-1:0] S_P_DIV   = 5'd14;
  localparam logic [ST_W-1:0] S_N_MUL   = 5'd15;
  localparam logic [ST_W-1:0] S_N_DIV   = 5'd16;
  localparam logic [ST_W-1:0] S_A_MULLO = 5'd17;
  localparam logic [ST_W-1:0] S_A_MULHI = 5'd18;
  localparam logic [ST_W-1:0] S_A_DIV   = 5'd19;
  localparam logic [ST_W-1:0] S_NEXTJ   = 5'd20;
  localparam logic [ST_W-1:0] S_OUT     = 5'd21;

  logic [ST_W-1:0]          state;
  logic                     launched;
  sample_t                  smp;
  logic                     hsel;
  logic [FW-1:0]            fill [2];
  logic [SW-1:0]            head [2];
  logic [31:0]              lost [2];
  logic [SW-1:0]            wslot;
  logic [FW-1:0]            nf;
  logic [JW-1:0]            jidx;
  logic [31:0]              t0;
  logic [31:0]              t1;
  logic [31:0]              t2;
  logic [31:0]              span;
  logic [31:0]              dt1;
  logic [31:0]              dt2;
  logic [DIVISOR_W-1:0]     dsum;
  logic                     acc_ok;
  logic signed [15:0]       q0;
  logic signed [15:0]       q1;
  logic signed [15:0]       q2;
  logic [DIV_BITS-1:0]      num;
  logic signed [VP_W-1:0]   vp;
  logic signed [VP_W-1:0]   vn;
  logic [MUL_P_W-1:0]       prod_lo;
  logic signed [15:0]       held_pos [2*J];
  logic signed [VEL_W-1:0]  held_vel [2*J];
  logic signed [ACC_W-1:0]  held_acc [2*J];

  logic [HW-1:0]            k;
  logic signed [15:0]       qnew;
  logic [16:0]              dv;
  logic [16:0]              d1;
  logic [16:0]              d2;
  logic [VP_W:0]            diff;
  logic [VP_W-1:0]          dmag;
  logic [SW:0]              lidx;
  logic [SW-1:0]            rd_slot;
  logic [31:0]              span_c;
  logic [DIV_BITS-1:0]      acc_num;
  logic                     pos_we;
  logic                     time_we;
  logic [PAW-1:0]           pos_waddr;
  logic [PAW-1:0]           pos_raddr;
  logic [TAW-1:0]           time_waddr;
  logic [TAW-1:0]           time_raddr;
  logic [15:0]              prd;
  logic [31:0]              trd;
  unit_req_t                ureq;
  unit_stat_t               ustat;
  logic [DIV_BITS-1:0]      uopa;
  logic [DIVISOR_W-1:0]     uopb;
  logic [DIV_BITS-1:0]      uq;
  logic                     compute_st;

  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base, input logic [SW:0] off);
    logic [SW:0] s;
    s = {1'b0, base} + off;
    if (s >= (SW + 1)'(D)) begin
      s = s - (SW + 1)'(D);
    end
    return s[SW-1:0];
  endfunction

  function automatic logic signed [15:0] pos_pick(input sample_t s, input logic [JW-1:0] j);
    logic signed [15:0] p;
    case (int'(j))
      0: p = s.pos_a;
      1: p = s.pos_b;
      2: p = s.pos_c;
      3: p = s.pos_d;
      4: p = s.pos_e;
      5: p = s.pos_f;
      default: p = s.pos_a;
    endcase
    return p;
  endfunction

  function automatic logic [PAW-1:0] pos_addr(input logic h, input logic [SW-1:0] slot,
                                               input logic [JW-1:0] j);
    return PAW'(h) * PAW'(D * J) + PAW'(slot) * PAW'(J) + PAW'(j);
  endfunction

  function automatic logic [16:0] mag17(input logic [16:0] x);
    return x[16] ? 17'(-x) : x;
  endfunction

  function automatic logic signed [VEL_W-1:0] vel_sat(input logic neg,
                                                      input logic [DIV_BITS-1:0] m);
    logic signed [VEL_W-1:0] r;
    if (!neg) begin
      r = (|m[DIV_BITS-1:VEL_W-1]) ? {1'b0, {(VEL_W-1){1'b1}}} : m[VEL_W-1:0];
    end else if ((|m[DIV_BITS-1:VEL_W]) || (m[VEL_W-1] && (|m[VEL_W-2:0]))) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = -m[VEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] acc_sat(input logic neg,
                                                      input logic [DIV_BITS-1:0] m);
    logic signed [ACC_W-1:0] r;
    if (!neg) begin
      r = (|m[DIV_BITS-1:ACC_W-1]) ? {1'b0, {(ACC_W-1){1'b1}}} : m[ACC_W-1:0];
    end else if ((|m[DIV_BITS-1:ACC_W]) || (m[ACC_W-1] && (|m[ACC_W-2:0]))) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = -m[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VP_W-1:0] vq(input logic neg, input logic [DIV_BITS-1:0] m);
    return neg ? -m[VP_W-1:0] : m[VP_W-1:0];
  endfunction

  assign k      = HW'(hsel) * HW'(J) + HW'(jidx);
  assign qnew   = pos_pick(smp, jidx);
  assign dv     = {qnew[15], qnew} - {q0[15], q0};
  assign d1     = {q1[15], q1} - {q0[15], q0};
  assign d2     = {q2[15], q2} - {q1[15], q1};
  assign diff   = {vn[VP_W-1], vn} - {vp[VP_W-1], vp};
  assign dmag   = diff[VP_W] ? VP_W'(-diff) : diff[VP_W-1:0];
  assign span_c = smp.time_us - t0;
  assign acc_num = DIV_BITS'({uq[MUL_P_W-1:0], {MUL_A_W{1'b0}}}) + DIV_BITS'(prod_lo);

  always_comb begin
    case (state)
      S_RT1, S_RQ1: lidx = (SW + 1)'(1);
      S_RT2, S_RQ2: lidx = (SW + 1)'(2);
      default:      lidx = '0;
    endcase
  end

  assign rd_slot    = slot_of(head[hsel], lidx);
  assign pos_we     = (state == S_WRITE);
  assign time_we    = (state == S_WRITE) && (jidx == '0);
  assign pos_waddr  = pos_addr(hsel, wslot, jidx);
  assign pos_raddr  = pos_addr(hsel, rd_slot, jidx);
  assign time_waddr = TAW'(hsel) * TAW'(D) + TAW'(wslot);
  assign time_raddr = TAW'(hsel) * TAW'(D) + TAW'(rd_slot);

  wvae_ram #(
    .WIDTH(16),
    .DEPTH(PDEPTH)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(pos_waddr),
    .wdata(qnew),
    .raddr(pos_raddr),
    .rdata(prd)
  );

  wvae_ram #(
    .WIDTH(32),
    .DEPTH(TDEPTH)
  ) u_time_ram (
    .clk  (clk),
    .we   (time_we),
    .waddr(time_waddr),
    .wdata(smp.time_us),
    .raddr(time_raddr),
    .rdata(trd)
  );

  always_comb begin
    compute_st = 1'b1;
    ureq.op    = OP_DIV;
    uopa       = num;
    uopb       = '0;
    case (state)
      S_VMUL: begin
        ureq.op = OP_MUL;
        uopa    = DIV_BITS'(mag17(dv));
      end
      S_VDIV:  uopb = {1'b0, span};
      S_P_MUL: begin
        ureq.op = OP_MUL;
        uopa    = DIV_BITS'(mag17(d1));
      end
      S_P_DIV: uopb = {1'b0, dt1};
      S_N_MUL: begin
        ureq.op = OP_MUL;
        uopa    = DIV_BITS'(mag17(d2));
      end
      S_N_DIV: uopb = {1'b0, dt2};
      S_A_MULLO: begin
        ureq.op = OP_MUL;
        uopa    = DIV_BITS'(dmag[MUL_A_W-1:0]);
      end
      S_A_MULHI: begin
        ureq.op = OP_MUL;
        uopa    = DIV_BITS'(dmag[VP_W-1:MUL_A_W]);
      end
      S_A_DIV: uopb = dsum;
      default: compute_st = 1'b0;
    endcase
    ureq.start = compute_st && !launched;
  end

  wvae_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .req     (ureq),
    .opa     (uopa),
    .opb     (uopb),
    .stat    (ustat),
    .quotient(uq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      jidx     <= '0;
      for (int i = 0; i < 2; i++) begin
        fill[i] <= '0;
        head[i] <= '0;
        lost[i] <= '0;
      end
      for (int i = 0; i < 2 * J; i++) begin
        held_pos[i] <= '0;
        held_vel[i] <= '0;
        held_acc[i] <= '0;
      end
    end else begin
      if (ustat.done) begin
        launched <= 1'b0;
      end else if (ureq.start) begin
        launched <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            smp  <= sample;
            hsel <= sample.hand;
            jidx <= '0;
            if (!sample.read_ok) begin
              lost[sample.hand] <= lost[sample.hand] + 32'd1;
              state             <= S_OUT;
            end else begin
              if (fill[sample.hand] == FW'(D)) begin
                wslot             <= head[sample.hand];
                head[sample.hand] <= slot_of(head[sample.hand], (SW + 1)'(1));
                nf                <= FW'(D);
              end else begin
                wslot             <= slot_of(head[sample.hand], (SW + 1)'(fill[sample.hand]));
                fill[sample.hand] <= fill[sample.hand] + FW'(1);
                nf                <= fill[sample.hand] + FW'(1);
              end
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (nf >= FW'(2)) begin
            held_pos[k] <= qnew;
          end
          if (jidx == JW'(J - 1)) begin
            jidx  <= '0;
            state <= (nf >= FW'(2)) ? S_RT0 : S_OUT;
          end else begin
            jidx <= jidx + JW'(1);
          end
        end
        S_RT0: state <= S_RT1;
        S_RT1: begin
          t0    <= trd;
          state <= S_RT2;
        end
        S_RT2: begin
          t1    <= trd;
          state <= S_RT3;
        end
        S_RT3: begin
          t2    <= trd;
          state <= S_CHK;
        end
        S_CHK: begin
          if (span_c == '0) begin
            state <= S_OUT;
          end else begin
            span   <= span_c;
            dt1    <= t1 - t0;
            dt2    <= t2 - t1;
            dsum   <= {1'b0, t1 - t0} + {1'b0, t2 - t1};
            acc_ok <= (nf >= FW'(3)) && (t1 != t0) && (t2 != t1);
            state  <= S_RQ0;
          end
        end
        S_RQ0: state <= S_RQ1;
        S_RQ1: begin
          q0    <= prd;
          state <= S_RQ2;
        end
        S_RQ2: begin
          q1    <= prd;
          state <= S_RQ3;
        end
        S_RQ3: begin
          q2    <= prd;
          state <= S_VMUL;
        end
        S_VMUL: begin
          if (ustat.done) begin
            num   <= uq;
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (ustat.done) begin
            held_vel[k] <= vel_sat(dv[16], uq);
            state       <= acc_ok ? S_P_MUL : S_NEXTJ;
          end
        end
        S_P_MUL: begin
          if (ustat.done) begin
            num   <= uq;
            state <= S_P_DIV;
          end
        end
        S_P_DIV: begin
          if (ustat.done) begin
            vp    <= vq(d1[16], uq);
            state <= S_N_MUL;
          end
        end
        S_N_MUL: begin
          if (ustat.done) begin
            num   <= uq;
            state <= S_N_DIV;
          end
        end
        S_N_DIV: begin
          if (ustat.done) begin
            vn    <= vq(d2[16], uq);
            state <= S_A_MULLO;
          end
        end
        S_A_MULLO: begin
          if (ustat.done) begin
            prod_lo <= uq[MUL_P_W-1:0];
            state   <= S_A_MULHI;
          end
        end
        S_A_MULHI: begin
          if (ustat.done) begin
            num   <= {acc_num[DIV_BITS-2:0], 1'b0};
            state <= S_A_DIV;
          end
        end
        S_A_DIV: begin
          if (ustat.done) begin
            held_acc[k] <= acc_sat(diff[VP_W], uq);
            state       <= S_NEXTJ;
          end
        end
        S_NEXTJ: begin
          if (jidx == JW'(J - 1)) begin
            jidx  <= '0;
            state <= S_OUT;
          end else begin
            jidx  <= jidx + JW'(1);
            state <= S_RQ0;
          end
        end
        S_OUT: begin
          if (!result_stall) begin
            if (jidx == JW'(J - 1)) begin
              jidx  <= '0;
              state <= S_IDLE;
            end else begin
              jidx <= jidx + JW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_stall        = (state != S_IDLE);
  assign result_valid        = (state == S_OUT);
  assign result.joint        = JOINT_W'(k);
  assign result.position     = held_pos[k];
  assign result.velocity     = held_vel[k];
  assign result.acceleration = held_acc[k];
  assign result.lost_count   = lost[hsel];
  assign result.last         = (jidx == JW'(J - 1));

  `WVAE_ASSERT_NEXT(a_lost_to_out, clk, rst, sample_valid && !sample_stall && !sample.read_ok, state == S_OUT)
  `WVAE_ASSERT_NEXT(a_last_to_idle, clk, rst, result_valid && !result_stall && result.last, state == S_IDLE)
  `WVAE_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, (fill[0] <= FW'(D)) && (fill[1] <= FW'(D)))

endmodule
